FILE: hdl/rmsn_pkg.sv
// Shared types and constants for the RMS row normalizer.
// Used by the iterative divide/root unit and by the top level.
`timescale 1ns / 1ps
package rmsn_pkg;
   localparam int ROW_MAX = 64;
   localparam int ADDR_W  = $clog2(ROW_MAX);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int SUM_W   = 37;
   localparam int NUM_W   = 48;
   localparam int DEN_W   = 24;
   localparam int REM_W   = 28;
   localparam int INV_W   = 37;

   typedef enum logic [1:0] {
      CSR_ROW_LENGTH   = 2'd0,
      CSR_EPSILON      = 2'd1,
      CSR_GAMMA_ENABLE = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_DIV  = 1'b0,
      OP_SQRT = 1'b1
   } unit_op_type;

   typedef struct packed {
      logic               start;
      unit_op_type        op;
      logic [NUM_W-1:0]   num;
      logic [DEN_W-1:0]   den;
   } unit_cmd_type;

   typedef struct packed {
      logic               done;
      logic [NUM_W-1:0]   quot;
   } unit_stat_type;
endpackage

FILE: hdl/rmsn_sqdiv.sv
// Shared one-bit-per-cycle unit: restoring division or digit-by-digit square root.
// Depends on rmsn_pkg for the command and status structs.
`timescale 1ns / 1ps
module rmsn_sqdiv (
   input  logic                   clock,
   input  logic                   reset,
   input  rmsn_pkg::unit_cmd_type cmd,
   output rmsn_pkg::unit_stat_type stat
);
   import rmsn_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   unit_op_type       op_ff, op_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  quot_ff, quot_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [REM_W-1:0]  rem_sh, trial;
   logic              ge;

   // The same compare and subtract serves both operations.
   always_comb begin
      if (op_ff == OP_SQRT) begin
         rem_sh = {rem_ff[REM_W-3:0], num_ff[NUM_W-1 -: 2]};
         trial  = {quot_ff[REM_W-3:0], 2'b01};
      end else begin
         rem_sh = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
         trial  = {{(REM_W-DEN_W){1'b0}}, den_ff};
      end
      ge = (rem_sh >= trial);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (busy_ff) begin
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         quot_in = {quot_ff[NUM_W-2:0], ge};
         num_in  = (op_ff == OP_SQRT) ? (num_ff << 2) : (num_ff << 1);
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         num_in  = cmd.num;
         den_in  = cmd.den;
         quot_in = '0;
         rem_in  = '0;
         cnt_in  = (cmd.op == OP_SQRT) ? 6'(NUM_W / 2 - 1) : 6'(NUM_W - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign stat.done = done_ff;
   assign stat.quot = quot_ff;
endmodule

FILE: hdl/rms_row_normalizer_core.sv
// RMS row normalizer top level: row buffers, sequencer and output register.
// Depends on rmsn_pkg and rmsn_sqdiv.
//
// Usage: the req channel carries one row element (sample, gamma_weight, Q4.12)
// per transfer; the rsp channel returns the normalized row, one element per
// transfer, with rsp_row_last on the final element. The csr port writes
// row_length, epsilon and gamma_enable; the user must write them only while
// the block is idle, which the block itself does not enforce. Loading writes
// each element into the row buffers and adds its square to the sum. After the
// last element the shared divide/root unit runs the mean and root passes and,
// unless the root is zero, the reciprocal pass. Each element is then produced
// through one memory read, two partial products, rounding, the gamma product
// and saturation. req_stall is high from the row's last transfer until the
// final result has been taken.
// Reset (synchronous) empties the row, drops any pending result and returns
// registers to row_length 64, epsilon 17, gamma disabled. While rsp_stall is
// high a held result waits, and so does the emit sequence at its output step.
`timescale 1ns / 1ps
module rms_row_normalizer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_sample,
   input  logic [15:0] req_gamma_weight,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_normalized,
   output logic        rsp_row_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);
   import rmsn_pkg::*;

   typedef enum logic [3:0] {
      S_LOAD, S_MEAN, S_MEAN_W, S_ROOT, S_ROOT_W, S_RECIP, S_RECIP_W,
      S_READ, S_MLO, S_MHI, S_RND, S_GAM, S_OUT, S_DRAIN
   } state_type;

   state_type           state_ff;
   logic [6:0]          row_length_ff;
   logic [23:0]         epsilon_ff;
   logic                gamma_enable_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]    count_ff, elem_ff;
   logic [31:0]         mean_ff;
   logic [INV_W-1:0]    inv_ff;
   logic signed [15:0]  x_ff, w_ff;
   logic signed [36:0]  plo_ff;
   logic signed [53:0]  acc_ff;
   logic signed [29:0]  v_ff;
   logic signed [45:0]  g_ff;
   logic                rsp_valid_ff;
   logic [15:0]         rsp_normalized_ff;
   logic                rsp_row_last_ff;

   logic [15:0]         row_mem [ROW_MAX];
   logic [15:0]         weight_mem [ROW_MAX];

   unit_cmd_type        cmd;
   unit_stat_type       stat;
   logic [CNT_W-1:0]    row_n;
   logic                accept;
   logic signed [31:0]  square;
   logic signed [33:0]  p_hi;
   logic signed [53:0]  acc_sum;
   logic signed [33:0]  g_rnd;
   logic signed [33:0]  pre_sat;
   logic [15:0]         sat_val;
   logic                out_free;
   logic                last_elem;

   rmsn_sqdiv u_sqdiv (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   always_comb begin
      if (row_length_ff == 7'd0) begin
         row_n = CNT_W'(1);
      end else if (row_length_ff > 7'(ROW_MAX)) begin
         row_n = CNT_W'(ROW_MAX);
      end else begin
         row_n = CNT_W'(row_length_ff);
      end
   end

   assign accept    = req_valid && (state_ff == S_LOAD);
   assign req_stall = (state_ff != S_LOAD);
   assign square    = 32'($signed(req_sample)) * 32'($signed(req_sample));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_elem = (elem_ff + CNT_W'(1) == count_ff);

   always_comb begin
      cmd.start = 1'b0;
      cmd.op    = OP_DIV;
      cmd.num   = NUM_W'(sum_ff);
      cmd.den   = DEN_W'(count_ff);
      unique case (state_ff)
         S_MEAN: begin
            cmd.start = 1'b1;
         end
         S_ROOT: begin
            cmd.start = 1'b1;
            cmd.op    = OP_SQRT;
            cmd.num   = {mean_ff, 16'd0};
         end
         S_RECIP: begin
            cmd.start = 1'b1;
            cmd.num   = NUM_W'(1) << 44;
            cmd.den   = DEN_W'(inv_ff);
         end
         default: begin
            cmd.start = 1'b0;
         end
      endcase
   end

   // Datapath of the emit pass.
   always_comb begin
      p_hi    = 34'(x_ff) * 34'($signed({1'b0, inv_ff[36:20]}));
      acc_sum = 54'(plo_ff) + (54'(p_hi) <<< 20);
      g_rnd   = 34'((g_ff + 46'sd2048) >>> 12);
      pre_sat = gamma_enable_ff ? g_rnd : 34'(v_ff);
      if (pre_sat > 34'sd32767) begin
         sat_val = 16'h7fff;
      end else if (pre_sat < -34'sd32768) begin
         sat_val = 16'h8000;
      end else begin
         sat_val = pre_sat[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_mem[count_ff[ADDR_W-1:0]]    <= req_sample;
         weight_mem[count_ff[ADDR_W-1:0]] <= req_gamma_weight;
      end
      x_ff <= row_mem[elem_ff[ADDR_W-1:0]];
      w_ff <= weight_mem[elem_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_LOAD;
         row_length_ff   <= 7'd64;
         epsilon_ff      <= 24'd17;
         gamma_enable_ff <= 1'b0;
         sum_ff          <= '0;
         count_ff        <= '0;
         elem_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_ROW_LENGTH:   row_length_ff   <= csr_data[6:0];
               CSR_EPSILON:      epsilon_ff      <= csr_data;
               CSR_GAMMA_ENABLE: gamma_enable_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
         // In S_OUT the output register is reloaded below instead.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  sum_ff   <= sum_ff + SUM_W'(unsigned'(square));
                  count_ff <= count_ff + CNT_W'(1);
                  if (count_ff + CNT_W'(1) >= row_n) begin
                     state_ff <= S_MEAN;
                  end
               end
            end
            S_MEAN:   state_ff <= S_MEAN_W;
            S_MEAN_W: begin
               if (stat.done) begin
                  mean_ff  <= stat.quot[31:0] + 32'(epsilon_ff);
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT:   state_ff <= S_ROOT_W;
            S_ROOT_W: begin
               if (stat.done) begin
                  // A zero root gives a zero factor and all-zero outputs.
                  inv_ff  <= INV_W'(stat.quot[DEN_W-1:0]);
                  elem_ff <= '0;
                  if (stat.quot[DEN_W-1:0] == '0) begin
                     state_ff <= S_READ;
                  end else begin
                     state_ff <= S_RECIP;
                  end
               end
            end
            S_RECIP:   state_ff <= S_RECIP_W;
            S_RECIP_W: begin
               if (stat.done) begin
                  inv_ff   <= stat.quot[INV_W-1:0];
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_MLO;
            S_MLO: begin
               plo_ff   <= 37'(x_ff) * 37'($signed({1'b0, inv_ff[19:0]}));
               state_ff <= S_MHI;
            end
            S_MHI: begin
               acc_ff   <= acc_sum;
               state_ff <= S_RND;
            end
            S_RND: begin
               v_ff     <= 30'((acc_ff + 54'sd8388608) >>> 24);
               state_ff <= S_GAM;
            end
            S_GAM: begin
               g_ff     <= 46'(v_ff) * 46'(w_ff);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_normalized_ff <= sat_val;
                  rsp_row_last_ff   <= last_elem;
                  elem_ff           <= elem_ff + CNT_W'(1);
                  if (last_elem) begin
                     sum_ff   <= '0;
                     count_ff <= '0;
                     state_ff <= S_DRAIN;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_DRAIN: begin
               if (out_free) begin
                  state_ff <= S_LOAD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normalized = rsp_normalized_ff;
   assign rsp_row_last   = rsp_row_last_ff;
endmodule

FILE: hdl/rmsn_checker.sv
// Port-level checks for the RMS row normalizer, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module rmsn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_normalized,
   input logic        rsp_row_last
);
   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_normalized)
                                 && $stable(rsp_row_last))
      else $error("stalled result changed");

   // No element is taken while results of a row are pending.
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while results pending");

   // A result never follows an input transfer in the next cycle.
   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result too early after input transfer");

   // Reset drops any pending result.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind rms_row_normalizer_core rmsn_checker u_rmsn_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_normalized (rsp_normalized),
   .rsp_row_last   (rsp_row_last)
);
